// ===== src/pidsw_pkg.sv =====
//------------------------------------------------------------------------------
// pidsw_pkg
// Types, register map and microcode for the setpoint-weighted PID core.
//------------------------------------------------------------------------------
package pidsw_pkg;

	localparam int STEP_W = 3;
	localparam int ACC_W  = 58;
	localparam int ERR_W  = 18;

	localparam logic [2:0] REG_GAIN_P   = 3'd0;
	localparam logic [2:0] REG_GAIN_I   = 3'd1;
	localparam logic [2:0] REG_GAIN_D   = 3'd2;
	localparam logic [2:0] REG_WEIGHT_P = 3'd3;
	localparam logic [2:0] REG_WEIGHT_D = 3'd4;
	localparam logic [2:0] REG_BIAS     = 3'd5;
	localparam logic [2:0] REG_OUT_MAX  = 3'd6;
	localparam logic [2:0] REG_OUT_MIN  = 3'd7;

	typedef enum logic [2:0] {
		A_WP, A_WD, A_GP, A_GI, A_GD
	} asel_t;

	typedef enum logic [1:0] {
		B_SP, B_EP, B_INT, B_DD
	} bsel_t;

	typedef enum logic [2:0] {
		ACT_NONE, ACT_EP, ACT_ED, ACT_ACC_SET, ACT_ACC_ADD, ACT_OUT, ACT_ZERO
	} act_t;

	typedef enum logic [1:0] {
		C_ALWAYS, C_GI, C_GD
	} cond_t;

	typedef enum logic [1:0] {
		AUX_NONE, AUX_INT, AUX_DD, AUX_PREV
	} aux_t;

	typedef enum logic {
		J_NONE, J_STOP
	} jmp_t;

	typedef struct packed {
		asel_t             asel;
		bsel_t             bsel;
		act_t              act;
		cond_t             cond;
		aux_t              aux;
		jmp_t              jmp;
		logic [STEP_W-1:0] target;
		logic              last;
	} ctrl_word_t;

	localparam logic [STEP_W-1:0] STEP_ZERO = 3'd7;

	function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
		ctrl_word_t cw;
		cw = '{asel: A_WP, bsel: B_SP, act: ACT_NONE, cond: C_ALWAYS, aux: AUX_NONE,
		       jmp: J_NONE, target: '0, last: 1'b0};
		unique case (step)
			3'd0: begin
				cw.jmp    = J_STOP;
				cw.target = STEP_ZERO;
			end
			3'd1: begin
				cw.asel = A_WD;
				cw.act  = ACT_EP;
			end
			3'd2: begin
				cw.asel = A_GP;
				cw.bsel = B_EP;
				cw.act  = ACT_ED;
				cw.aux  = AUX_INT;
			end
			3'd3: begin
				cw.asel = A_GI;
				cw.bsel = B_INT;
				cw.act  = ACT_ACC_SET;
				cw.aux  = AUX_DD;
			end
			3'd4: begin
				cw.asel = A_GD;
				cw.bsel = B_DD;
				cw.act  = ACT_ACC_ADD;
				cw.cond = C_GI;
			end
			3'd5: begin
				cw.act  = ACT_ACC_ADD;
				cw.cond = C_GD;
				cw.aux  = AUX_PREV;
			end
			3'd6: begin
				cw.act  = ACT_OUT;
				cw.last = 1'b1;
			end
			3'd7: begin
				cw.act  = ACT_ZERO;
				cw.last = 1'b1;
			end
			default: begin
				cw.last = 1'b1;
			end
		endcase
		return cw;
	endfunction

endpackage

// ===== src/pid_setpoint_weighted_core.sv =====
//------------------------------------------------------------------------------
// pid_setpoint_weighted_core
// Discrete PID controller with setpoint weighting, microcoded datapath.
//------------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample per transaction: tdata = measured[15:0],
//   setpoint[31:16]; tuser = run. m_axis returns one transaction per sample:
//   tdata = drive[15:0].
//   A sample runs through a seven-step microprogram on one shared 24x32
//   multiplier; drive is registered on the output step (on the zero step
//   when run is clear, the program jumping straight to it). One sample at
//   a time: s_axis_tready is high while the sequencer is idle, so a new
//   sample is taken only once the last one has finished its program.
//   The result sits in an output register; the next sample is accepted
//   while it waits. If the receiver still stalls when the next result is
//   due, the sequencer holds on its final step until the register frees.
//   APB registers at 4*i: gain_p, gain_i, gain_d, weight_p, weight_d, bias,
//   out_max, out_min. Write only while idle; pready is tied high.
//   Reset clears the integrator and stored derivative error and loads the
//   register defaults (unity weights, full-scale limits, zero gains).
//------------------------------------------------------------------------------
module pid_setpoint_weighted_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // measured[15:0], setpoint[31:16]
	input  logic        s_axis_tuser,   // run
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // drive[15:0]
);
	import pidsw_pkg::*;

	logic signed [23:0] gain_p_q, gain_i_q, gain_d_q;
	logic signed [15:0] weight_p_q, weight_d_q, bias_q, out_max_q, out_min_q;

	logic                    busy_q;
	logic [STEP_W-1:0]       step_q;
	logic                    out_valid_q;
	logic [15:0]             drive_q;
	logic signed [15:0]      meas_q, sp_q;
	logic                    run_q;
	logic signed [55:0]      prod_q;
	logic signed [ERR_W-1:0] ep_q, ed_q, prev_q;
	logic signed [ERR_W:0]   dd_q;
	logic signed [31:0]      integ_q;
	logic signed [ACC_W-1:0] acc_q;

	ctrl_word_t              cw;
	logic                    cfg_wr, in_fire, hold, adv, act_en, res_ld;
	logic                    gi_nz, gd_nz;
	logic [STEP_W-1:0]       step_nx;
	logic signed [23:0]      mul_a;
	logic signed [31:0]      mul_b;
	logic signed [55:0]      mul_p;
	logic signed [32:0]      wsum;
	logic signed [ERR_W:0]   werr;
	logic signed [32:0]      isum;
	logic signed [31:0]      isat;
	logic signed [ACC_W-1:0] prod_x, hi, lo, u_clamp, rsum;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q   <= '0;
			gain_i_q   <= '0;
			gain_d_q   <= '0;
			weight_p_q <= 16'sd16384;
			weight_d_q <= 16'sd16384;
			bias_q     <= '0;
			out_max_q  <= 16'sh7fff;
			out_min_q  <= 16'sh8000;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_GAIN_P:   gain_p_q   <= pwdata[23:0];
				REG_GAIN_I:   gain_i_q   <= pwdata[23:0];
				REG_GAIN_D:   gain_d_q   <= pwdata[23:0];
				REG_WEIGHT_P: weight_p_q <= pwdata[15:0];
				REG_WEIGHT_D: weight_d_q <= pwdata[15:0];
				REG_BIAS:     bias_q     <= pwdata[15:0];
				REG_OUT_MAX:  out_max_q  <= pwdata[15:0];
				REG_OUT_MIN:  out_min_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_GAIN_P:   prdata = {{8{gain_p_q[23]}}, gain_p_q};
			REG_GAIN_I:   prdata = {{8{gain_i_q[23]}}, gain_i_q};
			REG_GAIN_D:   prdata = {{8{gain_d_q[23]}}, gain_d_q};
			REG_WEIGHT_P: prdata = {{16{weight_p_q[15]}}, weight_p_q};
			REG_WEIGHT_D: prdata = {{16{weight_d_q[15]}}, weight_d_q};
			REG_BIAS:     prdata = {{16{bias_q[15]}}, bias_q};
			REG_OUT_MAX:  prdata = {{16{out_max_q[15]}}, out_max_q};
			REG_OUT_MIN:  prdata = {{16{out_min_q[15]}}, out_min_q};
			default:      prdata = '0;
		endcase
	end

	// sequencer
	assign cw      = ucode_rom(step_q);
	assign gi_nz   = (gain_i_q != '0);
	assign gd_nz   = (gain_d_q != '0);
	assign s_axis_tready = !busy_q;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign hold    = ((cw.act == ACT_OUT) || (cw.act == ACT_ZERO))
	                 && out_valid_q && !m_axis_tready;
	assign adv     = busy_q && !hold;
	assign res_ld  = adv && ((cw.act == ACT_OUT) || (cw.act == ACT_ZERO));
	assign step_nx = ((cw.jmp == J_STOP) && !run_q) ? cw.target : step_q + 1'b1;

	always_comb begin
		case (cw.cond)
			C_GI:    act_en = gi_nz;
			C_GD:    act_en = gd_nz;
			default: act_en = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (adv) begin
				if (cw.last) begin
					busy_q <= 1'b0;
					step_q <= '0;
				end else begin
					step_q <= step_nx;
				end
			end
			if (m_axis_tready)
				out_valid_q <= 1'b0;
			if (res_ld)
				out_valid_q <= 1'b1;
		end
	end

	// shared multiplier operands
	always_comb begin
		case (cw.asel)
			A_WD:    mul_a = {{8{weight_d_q[15]}}, weight_d_q};
			A_GP:    mul_a = gain_p_q;
			A_GI:    mul_a = gain_i_q;
			A_GD:    mul_a = gain_d_q;
			default: mul_a = {{8{weight_p_q[15]}}, weight_p_q};
		endcase
		case (cw.bsel)
			B_EP:    mul_b = {{(32-ERR_W){ep_q[ERR_W-1]}}, ep_q};
			B_INT:   mul_b = integ_q;
			B_DD:    mul_b = {{(31-ERR_W){dd_q[ERR_W]}}, dd_q};
			default: mul_b = {{16{sp_q[15]}}, sp_q};
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// weighted error: round half up of w*sp / 2^14, minus measurement
	assign wsum = {prod_q[31], prod_q[31:0]} + 33'sd8192;
	assign werr = wsum[32:14] - {{(ERR_W-15){meas_q[15]}}, meas_q};

	assign isum = {integ_q[31], integ_q} + {{(33-ERR_W){ep_q[ERR_W-1]}}, ep_q};
	assign isat = (isum[32] != isum[31]) ? (isum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
	                                     : isum[31:0];

	assign prod_x  = {{(ACC_W-56){prod_q[55]}}, prod_q};
	assign hi      = {{(ACC_W-32){out_max_q[15]}}, out_max_q, 16'b0};
	assign lo      = {{(ACC_W-32){out_min_q[15]}}, out_min_q, 16'b0};
	assign u_clamp = (acc_q > hi) ? hi : ((acc_q < lo) ? lo : acc_q);
	assign rsum    = u_clamp + {{(ACC_W-16){1'b0}}, 16'h8000};

	always_ff @(posedge clk) begin
		if (in_fire) begin
			meas_q <= s_axis_tdata[15:0];
			sp_q   <= s_axis_tdata[31:16];
			run_q  <= s_axis_tuser;
		end
		if (adv) begin
			prod_q <= mul_p;
			if (act_en) begin
				case (cw.act)
					ACT_EP:      ep_q  <= werr[ERR_W-1:0];
					ACT_ED:      ed_q  <= werr[ERR_W-1:0];
					ACT_ACC_SET: acc_q <= {{(ACC_W-32){bias_q[15]}}, bias_q, 16'b0} + prod_x;
					ACT_ACC_ADD: acc_q <= acc_q + prod_x;
					ACT_OUT:     drive_q <= rsum[31:16];
					ACT_ZERO:    drive_q <= '0;
					default: ;
				endcase
			end
			case (cw.aux)
				AUX_DD:   dd_q <= {ed_q[ERR_W-1], ed_q} - {prev_q[ERR_W-1], prev_q};
				default: ;
			endcase
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
		end else if (adv) begin
			if ((cw.aux == AUX_INT) && gi_nz)
				integ_q <= isat;
			if ((cw.aux == AUX_PREV) && gd_nz)
				prev_q <= ed_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = drive_q;

endmodule
